FILE: hdl/pdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_pkg: shared types and constants of the buck PI duty controller
// Register map, configuration record, loop constants and PWM limits.
// ----------------------------------------------------------------------------
package pdc_pkg;

	// Field widths of the channels and the configuration port
	localparam int SAMPLE_W  = 10;
	localparam int DUTY_W    = 9;
	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 3;
	localparam int GAIN_W    = 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_TARGET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_SHIFT     = 3'd4;

	// Register reset values
	localparam logic [SAMPLE_W-1:0] RST_VOLTAGE_TARGET = '0;
	localparam logic [SAMPLE_W-1:0] RST_CURRENT_LIMIT  = '0;
	localparam logic [GAIN_W-1:0]   RST_PROP_GAIN      = 4'd6;
	localparam logic [GAIN_W-1:0]   RST_INTEG_GAIN     = 4'd4;
	localparam logic [GAIN_W-1:0]   RST_GAIN_SHIFT     = 4'd4;

	// PWM and loop constants
	localparam int PWM_PERIOD  = 480;
	localparam int DRIVE_MIN   = 8;
	localparam int DRIVE_MAX   = PWM_PERIOD - 60;
	localparam int RAMP_STEP   = 10;
	localparam int FALL_STEP   = 40;
	localparam int LEAK_SHIFT  = 3;
	localparam int SAMPLE_BITS = 10;

	// ADC samples keep at most SAMPLE_BITS low bits
	localparam int SAMPLE_EFF = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_EFF) - 1);

	localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(PWM_PERIOD);
	localparam logic [DUTY_W-1:0] DUTY_LO   = DUTY_W'(DRIVE_MIN);
	localparam logic [DUTY_W-1:0] DUTY_HI   = DUTY_W'(DRIVE_MAX);

	// Configuration register contents
	typedef struct packed {
		logic [SAMPLE_W-1:0] voltage_target;
		logic [SAMPLE_W-1:0] current_limit;
		logic [GAIN_W-1:0]   prop_gain;
		logic [GAIN_W-1:0]   integ_gain;
		logic [GAIN_W-1:0]   gain_shift;
	} cfg_t;

endpackage

FILE: hdl/pdc_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_sample_if: voltage and current sample channel
// Valid/ready channel carrying one ADC sample pair per transaction.
// ----------------------------------------------------------------------------
interface pdc_sample_if;
	logic                            valid;
	logic                            ready;
	logic [pdc_pkg::SAMPLE_W-1:0]    voltage_sample;
	logic [pdc_pkg::SAMPLE_W-1:0]    current_sample;

	modport source (output valid, output voltage_sample, output current_sample, input ready);
	modport sink   (input valid, input voltage_sample, input current_sample, output ready);
endinterface

FILE: hdl/pdc_duty_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_duty_if: PWM compare result channel
// Valid/ready channel carrying one compare value and protection flag.
// ----------------------------------------------------------------------------
interface pdc_duty_if;
	logic                          valid;
	logic                          ready;
	logic [pdc_pkg::DUTY_W-1:0]    duty_compare;
	logic                          protection_on;

	modport source (output valid, output duty_compare, output protection_on, input ready);
	modport sink   (input valid, input duty_compare, input protection_on, output ready);
endinterface

FILE: hdl/pdc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_cfg_regs: configuration register file
// Write-only registers for target, current limit, gains and shift.
// ----------------------------------------------------------------------------
module pdc_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pdc_pkg::CFG_W-1:0]       cfg_data,
	output pdc_pkg::cfg_t                   cfg
);

	pdc_pkg::cfg_t cfg_q;

	// Capture a write into the addressed register, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.voltage_target <= pdc_pkg::RST_VOLTAGE_TARGET;
			cfg_q.current_limit  <= pdc_pkg::RST_CURRENT_LIMIT;
			cfg_q.prop_gain      <= pdc_pkg::RST_PROP_GAIN;
			cfg_q.integ_gain     <= pdc_pkg::RST_INTEG_GAIN;
			cfg_q.gain_shift     <= pdc_pkg::RST_GAIN_SHIFT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pdc_pkg::REG_VOLTAGE_TARGET: begin
					cfg_q.voltage_target <= cfg_data[pdc_pkg::SAMPLE_W-1:0];
				end
				pdc_pkg::REG_CURRENT_LIMIT: begin
					cfg_q.current_limit <= cfg_data[pdc_pkg::SAMPLE_W-1:0];
				end
				pdc_pkg::REG_PROP_GAIN: begin
					cfg_q.prop_gain <= cfg_data[pdc_pkg::GAIN_W-1:0];
				end
				pdc_pkg::REG_INTEG_GAIN: begin
					cfg_q.integ_gain <= cfg_data[pdc_pkg::GAIN_W-1:0];
				end
				pdc_pkg::REG_GAIN_SHIFT: begin
					cfg_q.gain_shift <= cfg_data[pdc_pkg::GAIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/pdc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdc_datapath: one control step of the PI loop
// Protection, reference ramp, PI drive, duty limits and integrator update.
// ----------------------------------------------------------------------------
module pdc_datapath #(
	parameter int INTEG_LIMIT = 3000,
	parameter int IW          = 13
) (
	input  pdc_pkg::cfg_t                   cfg,
	input  logic [pdc_pkg::SAMPLE_W-1:0]    voltage_sample,
	input  logic [pdc_pkg::SAMPLE_W-1:0]    current_sample,
	input  logic signed [IW-1:0]            integ,
	input  logic [pdc_pkg::SAMPLE_W-1:0]    ramp,
	output logic signed [IW-1:0]            integ_next,
	output logic [pdc_pkg::SAMPLE_W-1:0]    ramp_next,
	output logic [pdc_pkg::DUTY_W-1:0]      duty_compare,
	output logic                            protection_on
);

	localparam int SW    = pdc_pkg::SAMPLE_W;
	localparam int ERR_W = SW + 1;
	localparam int SUM_W = (IW + 6 > 16) ? IW + 6 : 16;
	localparam int ACC_W = ((IW > ERR_W) ? IW : ERR_W) + 1;

	localparam logic signed [SUM_W-1:0] DMIN = SUM_W'(pdc_pkg::DRIVE_MIN);
	localparam logic signed [SUM_W-1:0] DMAX = SUM_W'(pdc_pkg::DRIVE_MAX);
	localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(INTEG_LIMIT);
	localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(-INTEG_LIMIT);
	localparam logic [SW-1:0] FALL = SW'(pdc_pkg::FALL_STEP);
	localparam logic [SW:0]   STEP = (SW + 1)'(pdc_pkg::RAMP_STEP);

	logic [SW-1:0]           volt;
	logic [SW-1:0]           curr;
	logic                    prot;
	logic signed [IW-1:0]    integ_leak;
	logic [SW:0]             ramp_up;
	logic [SW:0]             tgt_plus;
	logic signed [ERR_W-1:0] err;
	logic signed [SUM_W-1:0] p_term;
	logic signed [SUM_W-1:0] i_term;
	logic signed [SUM_W-1:0] drive;
	logic signed [ACC_W-1:0] acc;

	// Mask samples and detect overcurrent
	assign volt = voltage_sample & pdc_pkg::SAMPLE_MASK;
	assign curr = current_sample & pdc_pkg::SAMPLE_MASK;
	assign prot = curr > cfg.current_limit;

	// Leak the integrator by one eighth while protected
	assign integ_leak = prot ? integ - (integ >>> pdc_pkg::LEAK_SHIFT) : integ;

	// Slew the reference toward the target, or pull it down while protected
	assign ramp_up  = {1'b0, ramp} + STEP;
	assign tgt_plus = {1'b0, cfg.voltage_target} + STEP;

	always_comb begin
		ramp_next = ramp;
		if (prot) begin
			ramp_next = (ramp > FALL) ? ramp - FALL : '0;
		end else if (ramp < cfg.voltage_target) begin
			ramp_next = (ramp_up > {1'b0, cfg.voltage_target}) ? cfg.voltage_target
				: ramp_up[SW-1:0];
		end else if (ramp > cfg.voltage_target) begin
			ramp_next = ({1'b0, ramp} >= tgt_plus) ? ramp - STEP[SW-1:0] : cfg.voltage_target;
		end
	end

	// PI drive
	assign err    = $signed({1'b0, ramp_next}) - $signed({1'b0, volt});
	assign p_term = SUM_W'(err) * SUM_W'($signed({1'b0, cfg.prop_gain}));
	assign i_term = SUM_W'(integ_leak) * SUM_W'($signed({1'b0, cfg.integ_gain}));
	assign drive  = (p_term + i_term) >>> cfg.gain_shift;

	// Integrator accumulate with clamp
	assign acc = ACC_W'(integ_leak) + ACC_W'(err);

	// Limit the duty; accumulate into the integrator only in the linear band and while unprotected
	always_comb begin
		integ_next = integ_leak;
		if (drive < DMIN) begin
			duty_compare = '0;
		end else if (drive > DMAX) begin
			duty_compare = pdc_pkg::DUTY_FULL;
		end else begin
			duty_compare = drive[pdc_pkg::DUTY_W-1:0];
			if (!prot) begin
				if (acc > ACC_HI) begin
					integ_next = IW'(ACC_HI);
				end else if (acc < ACC_LO) begin
					integ_next = IW'(ACC_LO);
				end else begin
					integ_next = acc[IW-1:0];
				end
			end
		end
	end

	assign protection_on = prot;

endmodule

FILE: hdl/buck_pi_duty_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buck_pi_duty_controller: PI duty controller for a buck converter
// Turns each voltage/current sample pair into a PWM compare value, with
// overcurrent protection, a slewed reference and integrator anti-windup.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction payload
//  ---------+-----------+--------------------------------------------------
//  sample   | in        | voltage_sample[9:0], current_sample[9:0]
//  duty     | out       | duty_compare[8:0], protection_on
//  cfg_*    | in        | cfg_wr_en, cfg_index[2:0], cfg_data[9:0]
//
//  One sample pair per clock while the duty sink keeps up. An accepted
//  sample waits in the input register and moves into the result register
//  when that is free, which raises duty valid (input register, then result
//  register). The integrator and reference update in the cycle that a
//  sample moves into the result register. A stalled result register holds
//  its value while the input register still takes one more transaction.
//  Reset clears integrator, reference and all valid flags.
// ----------------------------------------------------------------------------
module buck_pi_duty_controller #(
	parameter int INTEGRATOR_LIMIT = 3000
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pdc_sample_if.sink                      sample,
	pdc_duty_if.source                      duty,
	input  logic                            cfg_wr_en,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pdc_pkg::CFG_W-1:0]       cfg_data
);

	localparam int IW = $clog2(INTEGRATOR_LIMIT + 1) + 1;
	localparam int SW = pdc_pkg::SAMPLE_W;
	localparam logic signed [IW-1:0] LIM_HI = IW'(INTEGRATOR_LIMIT);
	localparam logic signed [IW-1:0] LIM_LO = IW'(-INTEGRATOR_LIMIT);

	pdc_pkg::cfg_t                 cfg;
	logic                          valid_s1;
	logic [SW-1:0]                 volt_s1;
	logic [SW-1:0]                 curr_s1;
	logic                          out_valid_q;
	logic [pdc_pkg::DUTY_W-1:0]    duty_q;
	logic                          prot_q;
	logic signed [IW-1:0]          integ_q;
	logic [SW-1:0]                 ramp_q;
	logic signed [IW-1:0]          integ_next;
	logic [SW-1:0]                 ramp_next;
	logic [pdc_pkg::DUTY_W-1:0]    duty_next;
	logic                          prot_next;
	logic                          advance;

	pdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Move the held sample into the result register when it is free
	assign advance      = valid_s1 && (!out_valid_q || duty.ready);
	assign sample.ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			volt_s1 <= sample.voltage_sample;
			curr_s1 <= sample.current_sample;
		end
	end

	pdc_datapath #(
		.INTEG_LIMIT (INTEGRATOR_LIMIT),
		.IW          (IW)
	) u_dp (
		.cfg            (cfg),
		.voltage_sample (volt_s1),
		.current_sample (curr_s1),
		.integ          (integ_q),
		.ramp           (ramp_q),
		.integ_next     (integ_next),
		.ramp_next      (ramp_next),
		.duty_compare   (duty_next),
		.protection_on  (prot_next)
	);

	// Loop state advances once per transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			ramp_q  <= '0;
		end else if (advance) begin
			integ_q <= integ_next;
			ramp_q  <= ramp_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (duty.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			duty_q <= duty_next;
			prot_q <= prot_next;
		end
	end

	assign duty.valid         = out_valid_q;
	assign duty.duty_compare  = duty_q;
	assign duty.protection_on = prot_q;

	// Integrator never leaves its clamp range
	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		integ_q <= LIM_HI && integ_q >= LIM_LO)
		else $error("integrator outside clamp range");

	// Loop state holds without a transaction moving through
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(integ_q) && $stable(ramp_q))
		else $error("loop state changed without a transaction");

	// Duty is off, full period or inside the linear band
	a_duty_band: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (duty_q == '0 || duty_q == pdc_pkg::DUTY_FULL
			|| (duty_q >= pdc_pkg::DUTY_LO && duty_q <= pdc_pkg::DUTY_HI)))
		else $error("duty outside legal values");

	// Reference never rises on a protected transaction
	a_prot_ramp: assert property (@(posedge clk) disable iff (!arst_n)
		advance && prot_next |=> ramp_q <= $past(ramp_q))
		else $error("reference rose under protection");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the buck PI duty controller
// Sends voltage/current sample pairs in random bursts and checks each duty
// transaction against an in-bench image of the controller. The image tracks
// the slewed reference, the integrator and the register settings. The duty
// sink stalls on its own patterns and once holds off long enough to back up
// the sample channel.
// ----------------------------------------------------------------------------
module tb;

	localparam int CLK_HALF        = 4;
	localparam int INTEG_LIMIT     = 3000;
	localparam int IDLE_LIMIT      = 2000;
	localparam int PIPE_CYCLES     = 4;
	localparam int RANDOM_PHASES   = 7;
	localparam int ITEMS_PER_PHASE = 80;
	localparam int SAMPLE_MAX      = (1 << pdc_pkg::SAMPLE_W) - 1;
	localparam int GAIN_MAX        = (1 << pdc_pkg::GAIN_W) - 1;
	localparam int HOLD_CYCLES     = 200;

	typedef struct packed {
		logic [pdc_pkg::DUTY_W-1:0] duty_compare;
		logic                       protection_on;
	} duty_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [pdc_pkg::CFG_W-1:0]     cfg_data;

	pdc_sample_if sample_ch();
	pdc_duty_if   duty_ch();

	buck_pi_duty_controller #(
		.INTEGRATOR_LIMIT(INTEG_LIMIT)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.duty     (duty_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Register image and loop state of the controller
	logic [pdc_pkg::SAMPLE_W-1:0] cfg_target;
	logic [pdc_pkg::SAMPLE_W-1:0] cfg_limit;
	logic [pdc_pkg::GAIN_W-1:0]   cfg_kp;
	logic [pdc_pkg::GAIN_W-1:0]   cfg_ki;
	logic [pdc_pkg::GAIN_W-1:0]   cfg_shift;
	logic signed [12:0]           pi_integ;
	logic [pdc_pkg::SAMPLE_W-1:0] pi_ref;

	duty_result_t duty_expect_q[$];

	int fail_count  = 0;
	int idle_cycles = 0;
	int burst_left;
	bit tx_steady;
	int rx_hold_len;
	bit rx_hold_go;

	// Clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Advance the controller image by one sample pair and queue its duty result
	task automatic predict_duty(input logic [pdc_pkg::SAMPLE_W-1:0] v,
			input logic [pdc_pkg::SAMPLE_W-1:0] c);
		longint integ, rf, tgt, vv, err, kp, ki, drive;
		logic prot;
		duty_result_t res;
		integ = pi_integ;
		rf    = pi_ref;
		tgt   = cfg_target;
		vv    = v;
		kp    = cfg_kp;
		ki    = cfg_ki;
		prot  = (c > cfg_limit);

		// Overcurrent leaks the integrator and drops the reference; else slew
		if (prot) begin
			integ = integ - (integ >>> pdc_pkg::LEAK_SHIFT);
			rf = (rf > pdc_pkg::FALL_STEP) ? rf - pdc_pkg::FALL_STEP : 0;
		end else if (rf < tgt) begin
			rf = rf + pdc_pkg::RAMP_STEP;
			if (rf > tgt)
				rf = tgt;
		end else if (rf > tgt) begin
			rf = (rf >= tgt + pdc_pkg::RAMP_STEP) ? rf - pdc_pkg::RAMP_STEP : tgt;
		end

		err   = rf - vv;
		drive = (kp * err + ki * integ) >>> cfg_shift;

		// Saturate at both ends; integrate only in the linear band
		if (drive < pdc_pkg::DRIVE_MIN) begin
			res.duty_compare = '0;
		end else if (drive > pdc_pkg::DRIVE_MAX) begin
			res.duty_compare = pdc_pkg::DUTY_FULL;
		end else begin
			res.duty_compare = pdc_pkg::DUTY_W'(drive);
			if (!prot) begin
				integ = integ + err;
				if (integ > INTEG_LIMIT)
					integ = INTEG_LIMIT;
				else if (integ < -INTEG_LIMIT)
					integ = -INTEG_LIMIT;
			end
		end
		res.protection_on = prot;

		pi_integ = 13'(integ);
		pi_ref   = pdc_pkg::SAMPLE_W'(rf);
		duty_expect_q.push_back(res);
	endtask

	// Offer one sample pair, hold it until accepted, then maybe pause
	task automatic send_sample(input logic [pdc_pkg::SAMPLE_W-1:0] v,
			input logic [pdc_pkg::SAMPLE_W-1:0] c);
		int gap;
		@(negedge clk);
		sample_ch.valid          = 1'b1;
		sample_ch.voltage_sample = v;
		sample_ch.current_sample = c;
		do @(posedge clk); while (!sample_ch.ready);
		predict_duty(v, c);
		if (!tx_steady) begin
			if (burst_left <= 0) begin
				gap = $urandom_range(1, 10);
				@(negedge clk);
				sample_ch.valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
				burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Drop valid and wait until every duty transaction is back
	task automatic drain_results();
		@(negedge clk);
		sample_ch.valid = 1'b0;
		while (duty_expect_q.size() != 0) @(posedge clk);
		repeat (PIPE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pdc_pkg::CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = pdc_pkg::CFG_W'(value);
		@(negedge clk);
		cfg_wr_en = 1'b0;
		case (idx)
			pdc_pkg::REG_VOLTAGE_TARGET: cfg_target = pdc_pkg::SAMPLE_W'(value);
			pdc_pkg::REG_CURRENT_LIMIT:  cfg_limit  = pdc_pkg::SAMPLE_W'(value);
			pdc_pkg::REG_PROP_GAIN:      cfg_kp     = pdc_pkg::GAIN_W'(value);
			pdc_pkg::REG_INTEG_GAIN:     cfg_ki     = pdc_pkg::GAIN_W'(value);
			pdc_pkg::REG_GAIN_SHIFT:     cfg_shift  = pdc_pkg::GAIN_W'(value);
			default: ;
		endcase
	endtask

	// Drain, then rewrite the whole register set
	task automatic apply_config(input int target, input int limit, input int kp,
			input int ki, input int shift);
		drain_results();
		write_reg(pdc_pkg::REG_VOLTAGE_TARGET, target);
		write_reg(pdc_pkg::REG_CURRENT_LIMIT, limit);
		write_reg(pdc_pkg::REG_PROP_GAIN, kp);
		write_reg(pdc_pkg::REG_INTEG_GAIN, ki);
		write_reg(pdc_pkg::REG_GAIN_SHIFT, shift);
	endtask

	// Register defaults: zero target, zero limit, edge samples
	task automatic test_reset_values();
		send_sample(0, 0);
		send_sample(SAMPLE_MAX, 0);
		send_sample(0, 1);
		send_sample(SAMPLE_MAX, SAMPLE_MAX);
	endtask

	// Ramp up without overshoot, ramp down, low, linear and high drive
	task automatic test_ramp_and_limits();
		apply_config(25, SAMPLE_MAX, GAIN_MAX, 0, 0);
		repeat (4) send_sample(0, 0);
		apply_config(3, SAMPLE_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
		repeat (3) send_sample(SAMPLE_MAX, 0);
		apply_config(SAMPLE_MAX, SAMPLE_MAX, GAIN_MAX, GAIN_MAX, 0);
		send_sample(0, SAMPLE_MAX);
		send_sample(SAMPLE_MAX, 0);
	endtask

	// Overcurrent at and around the limit, reference floored at zero
	task automatic test_overcurrent();
		apply_config(600, 512, 6, 4, 4);
		repeat (2) send_sample(0, 0);
		send_sample(SAMPLE_MAX, 513);
		send_sample(0, 512);
		repeat (3) send_sample(SAMPLE_MAX, SAMPLE_MAX);
	endtask

	// Closed-loop style traffic under several register settings
	task automatic test_regulation_random();
		int target, limit, kp, ki, shift, spread, pick, vi, ci;
		bit pull_down;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			pull_down = 1'b0;
			spread    = 40;
			case (phase)
				0: apply_config(SAMPLE_MAX, SAMPLE_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
				1: apply_config(0, 0, 0, 0, 0);
				2: begin
					// low samples against a high reference drive the integrator to its clamp
					apply_config(SAMPLE_MAX, SAMPLE_MAX, 1, 1, 6);
					pull_down = 1'b1;
					spread    = 900;
				end
				default: begin
					target = $urandom_range(50, SAMPLE_MAX);
					limit  = $urandom_range(0, SAMPLE_MAX);
					kp     = $urandom_range(0, GAIN_MAX);
					ki     = $urandom_range(0, GAIN_MAX);
					shift  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					apply_config(target, limit, kp, ki, shift);
					case ($urandom_range(0, 2))
						0: spread = 8;
						1: spread = 60;
						default: spread = 500;
					endcase
				end
			endcase

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					// voltage near the current reference, current at or under the limit
					if (pull_down)
						vi = int'(pi_ref) - int'($urandom_range(0, spread));
					else
						vi = int'(pi_ref) + int'($urandom_range(0, 2 * spread)) - spread;
					if (vi < 0)
						vi = 0;
					else if (vi > SAMPLE_MAX)
						vi = SAMPLE_MAX;
					ci = $urandom_range(0, cfg_limit);
				end else if (pick < 85 && cfg_limit != SAMPLE_MAX) begin
					// overcurrent burst
					vi = $urandom_range(0, SAMPLE_MAX);
					ci = $urandom_range(int'(cfg_limit) + 1, SAMPLE_MAX);
				end else begin
					vi = $urandom_range(0, SAMPLE_MAX);
					ci = $urandom_range(0, SAMPLE_MAX);
				end
				send_sample(pdc_pkg::SAMPLE_W'(vi), pdc_pkg::SAMPLE_W'(ci));
			end
		end
	endtask

	// Long sink hold-off while the source keeps offering
	task automatic test_output_backpressure();
		apply_config(500, 800, 6, 4, 4);
		rx_hold_len = HOLD_CYCLES;
		rx_hold_go  = 1'b1;
		tx_steady   = 1'b1;
		repeat (30)
			send_sample(pdc_pkg::SAMPLE_W'($urandom_range(0, SAMPLE_MAX)),
				pdc_pkg::SAMPLE_W'($urandom_range(0, 900)));
		tx_steady = 1'b0;
	endtask

	// Duty sink: stretches of full rate, random stalls and bit patterns
	initial begin
		int stretch_left, mode, hold_left;
		logic [15:0] pattern;
		duty_ch.ready = 1'b0;
		stretch_left  = 0;
		mode          = 0;
		hold_left     = 0;
		pattern       = '1;
		forever begin
			@(negedge clk);
			if (rx_hold_go) begin
				hold_left  = rx_hold_len;
				rx_hold_go = 1'b0;
			end
			if (hold_left > 0) begin
				duty_ch.ready = 1'b0;
				hold_left--;
			end else begin
				if (stretch_left == 0) begin
					stretch_left = $urandom_range(16, 80);
					mode         = $urandom_range(0, 2);
					pattern      = 16'($urandom);
				end
				stretch_left--;
				case (mode)
					0: duty_ch.ready = 1'b1;
					1: duty_ch.ready = ($urandom_range(0, 3) != 0);
					default: begin
						duty_ch.ready = pattern[0];
						pattern = {pattern[0], pattern[15:1]};
					end
				endcase
			end
		end
	end

	// Compare each duty transaction with the oldest expectation; watch for a hang
	always @(posedge clk) begin
		duty_result_t want;
		if ((sample_ch.valid && sample_ch.ready) || (duty_ch.valid && duty_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (arst_n && duty_ch.valid && duty_ch.ready) begin
			if (duty_expect_q.size() == 0) begin
				$display("%0t: unexpected duty transaction: duty_compare %0d protection_on %0b",
					$time, duty_ch.duty_compare, duty_ch.protection_on);
				fail_count++;
			end else begin
				want = duty_expect_q.pop_front();
				if (duty_ch.duty_compare !== want.duty_compare) begin
					$display("%0t: duty_compare mismatch: expected %0d, actual %0d",
						$time, want.duty_compare, duty_ch.duty_compare);
					fail_count++;
				end
				if (duty_ch.protection_on !== want.protection_on) begin
					$display("%0t: protection_on mismatch: expected %0b, actual %0b",
						$time, want.protection_on, duty_ch.protection_on);
					fail_count++;
				end
			end
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
			$display("buck_pi_duty_controller verification failed");
			$finish;
		end
	end

	// Reset, run the tests in turn, report
	initial begin
		arst_n                   = 1'b0;
		cfg_wr_en                = 1'b0;
		cfg_index                = pdc_pkg::REG_VOLTAGE_TARGET;
		cfg_data                 = '0;
		sample_ch.valid          = 1'b0;
		sample_ch.voltage_sample = '0;
		sample_ch.current_sample = '0;
		tx_steady                = 1'b0;
		burst_left               = 0;
		rx_hold_len              = 0;
		rx_hold_go               = 1'b0;
		cfg_target               = pdc_pkg::RST_VOLTAGE_TARGET;
		cfg_limit                = pdc_pkg::RST_CURRENT_LIMIT;
		cfg_kp                   = pdc_pkg::RST_PROP_GAIN;
		cfg_ki                   = pdc_pkg::RST_INTEG_GAIN;
		cfg_shift                = pdc_pkg::RST_GAIN_SHIFT;
		pi_integ                 = '0;
		pi_ref                   = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_values();
		test_ramp_and_limits();
		test_overcurrent();
		test_regulation_random();
		test_output_backpressure();

		drain_results();
		repeat (PIPE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("buck_pi_duty_controller verification clean");
		else
			$display("buck_pi_duty_controller verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/pdc_pkg.sv
hdl/pdc_sample_if.sv
hdl/pdc_duty_if.sv
hdl/pdc_cfg_regs.sv
hdl/pdc_datapath.sv
hdl/buck_pi_duty_controller.sv
dv/tb.sv
